[src/assert_macros.svh]
// assertion helper macros for the rtl sources
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[src/ctm_pkg.sv]
// ----------------------------------------------------------------------------
// ctm_pkg
// shared constants, types and tables of the cell temperature monitor
// ----------------------------------------------------------------------------
package ctm_pkg;
  localparam int unsigned Boards = 6;
  localparam int unsigned SensorsPerBoard = 48;
  localparam int unsigned FrameLen = 4;
  localparam int unsigned Cells = Boards * SensorsPerBoard;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned MemW = 18;
  localparam int unsigned SumW = 16 + $clog2(Cells) + 1;
  localparam logic [6:0] NoPosition = 7'd127;

  // average divide by 288 = 32 * 9: shift by 5, then multiply by ceil(2^25 / 9)
  localparam int unsigned AvgShift = 5;
  localparam int unsigned RecipShift = 25;
  localparam logic [21:0] AvgRecip = 22'd3728271;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_STATS  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic {
    REG_UNDER = 1'b0,
    REG_OVER  = 1'b1
  } reg_idx_e;

  function automatic logic [6:0] position_lookup(input logic [5:0] s);
    logic [6:0] r;
    case (s)
      6'd0: r = 7'd63;   6'd1: r = 7'd65;   6'd2: r = 7'd15;   6'd3: r = 7'd61;
      6'd4: r = 7'd6;    6'd5: r = 7'd39;   6'd6: r = 7'd46;   6'd7: r = 7'd7;
      6'd8: r = 7'd40;   6'd9: r = 7'd31;   6'd10: r = 7'd8;   6'd11: r = 7'd41;
      6'd12: r = 7'd64;  6'd13: r = 7'd36;  6'd14: r = 7'd54;  6'd15: r = 7'd1;
      6'd16: r = 7'd51;  6'd17: r = 7'd42;  6'd18: r = 7'd32;  6'd19: r = 7'd37;
      6'd20: r = 7'd55;  6'd21: r = 7'd48;  6'd22: r = 7'd52;  6'd23: r = 7'd43;
      6'd24: r = 7'd49;  6'd25: r = 7'd38;  6'd26: r = 7'd72;  6'd27: r = 7'd2;
      6'd28: r = 7'd9;   6'd29: r = 7'd44;  6'd30: r = 7'd33;  6'd31: r = 7'd67;
      6'd32: r = 7'd45;  6'd33: r = 7'd3;   6'd34: r = 7'd10;  6'd35: r = 7'd75;
      6'd36: r = 7'd34;  6'd37: r = 7'd11;  6'd38: r = 7'd57;  6'd39: r = 7'd4;
      6'd40: r = 7'd12;  6'd41: r = 7'd70;  6'd42: r = 7'd35;  6'd43: r = 7'd13;
      6'd44: r = 7'd69;  6'd45: r = 7'd5;   6'd46: r = 7'd14;  6'd47: r = 7'd73;
      default: r = NoPosition;
    endcase
    return r;
  endfunction
endpackage

[src/ctm_ram.sv]
// ----------------------------------------------------------------------------
// ctm_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ctm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[src/cell_temperature_monitor.sv]
// the statistics walk does one ram read per sensor and one reciprocal multiply;
// a rejected request or kind 3 goes straight to the result strobe.
// one request at a time, busy high until the result strobe; the next request
// can be taken at the strobe's edge. the result is shown for one cycle, no stall.
// after reset a clearing pass over all of the sample ram runs with busy high;
// configuration writes are taken only while idle with start low.
// ----------------------------------------------------------------------------
// cell_temperature_monitor
// sample table with limit flags, round-robin readout and statistics walk
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cell_temperature_monitor import ctm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         board_id_i,
  input  logic [5:0]         start_offset_i,
  input  logic signed [15:0] sample_zero_i,
  input  logic signed [15:0] sample_one_i,
  input  logic signed [15:0] sample_two_i,
  input  logic signed [15:0] sample_three_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic               status_o,
  output logic [2:0]         frame_board_o,
  output logic signed [15:0] value_a_o,
  output logic signed [15:0] value_b_o,
  output logic signed [15:0] value_c_o,
  output logic signed [15:0] value_d_o,
  output logic [6:0]         position_a_o,
  output logic [6:0]         position_b_o,
  output logic [6:0]         position_c_o,
  output logic [6:0]         position_d_o,
  output logic [3:0]         under_bits_o,
  output logic [3:0]         over_bits_o
);
  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_UPD, ST_FRM, ST_STAT, ST_DIV, ST_DONE
  } state_e;

  localparam int unsigned DivW = SumW;

  state_e state_q;
  logic [AddrW-1:0] addr_q;
  logic [2:0] step_q;
  logic [2:0] board_q;
  logic [5:0] offset_q;
  logic [2:0] rd_board_q;
  logic [5:0] rd_offset_q;
  logic signed [15:0] under_q, over_q;
  logic signed [15:0] samp_q [FrameLen];
  logic signed [15:0] val_q [FrameLen];
  logic [6:0] pos_q [FrameLen];
  logic [3:0] ub_q, ob_q;
  logic status_q, rvalid_q;
  logic rd_pend_q;
  logic signed [15:0] mx_q, mn_q;
  logic signed [SumW-1:0] sum_q;
  logic [DivW-1:0] quo_q;
  logic neg_q;

  // ram port
  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [MemW-1:0] ram_wdata, ram_rdata;
  logic signed [15:0] rd_val;
  assign rd_val = ram_rdata[15:0];

  ctm_ram #(.Width(MemW), .Depth(Cells)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // update lane data
  logic signed [15:0] cur_samp;
  logic cur_under, cur_over;
  assign cur_samp  = samp_q[step_q[1:0]];
  assign cur_under = cur_samp < under_q;
  assign cur_over  = cur_samp > over_q;

  // address forming
  logic [AddrW-1:0] upd_addr, frm_addr;
  logic [5:0] frm_s;
  assign upd_addr = AddrW'(board_q * SensorsPerBoard) + AddrW'(offset_q) + AddrW'(step_q[1:0]);
  assign frm_s    = rd_offset_q + 6'(step_q[1:0]);
  assign frm_addr = AddrW'(rd_board_q * SensorsPerBoard) + AddrW'(frm_s);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;
    case (state_q)
      ST_CLEAR: ram_we = 1'b1;
      ST_UPD: begin
        ram_we    = !step_q[2];
        ram_addr  = upd_addr;
        ram_wdata = {cur_over, cur_under, cur_samp};
      end
      ST_FRM:  ram_addr = frm_addr;
      default: ram_addr = addr_q;
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;

  // average by shift and reciprocal multiply of the sum magnitude
  logic signed [SumW-1:0] sum_fin;
  logic [DivW-AvgShift-1:0] avg_mag;
  logic [DivW-AvgShift+21:0] avg_prod;
  assign sum_fin  = sum_q + SumW'(rd_val);
  assign avg_mag  = quo_q[DivW-1:AvgShift];
  assign avg_prod = avg_mag * AvgRecip;

  // lane of the read issued at the previous step, wrapping within the frame
  logic [1:0] prev_lane;
  logic [5:0] prev_s;
  assign prev_lane = step_q[1:0] - 2'd1;
  assign prev_s    = rd_offset_q + 6'(prev_lane);

  // control, datapath and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      step_q      <= '0;
      rd_board_q  <= '0;
      rd_offset_q <= '0;
      under_q     <= 16'sd0;
      over_q      <= 16'sd7680;
      rvalid_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      rvalid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_idx_e'(cfg_index_i))
          REG_UNDER: under_q <= cfg_data_i;
          REG_OVER:  over_q  <= cfg_data_i;
          default:   ;
        endcase
      end
      case (state_q)
        ST_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == AddrW'(Cells - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            step_q   <= '0;
            addr_q   <= '0;
            board_q  <= board_id_i;
            offset_q <= start_offset_i;
            samp_q[0] <= sample_zero_i;
            samp_q[1] <= sample_one_i;
            samp_q[2] <= sample_two_i;
            samp_q[3] <= sample_three_i;
            status_q <= 1'b0;
            ub_q <= '0;
            ob_q <= '0;
            for (int i = 0; i < FrameLen; i++) begin
              val_q[i] <= '0;
              pos_q[i] <= '0;
            end
            mx_q <= '0;
            mn_q <= over_q;
            sum_q <= '0;
            rd_pend_q <= 1'b0;
            case (kind_e'(kind_i))
              KIND_UPDATE: begin
                if (32'(board_id_i) >= Boards ||
                    32'(start_offset_i) + FrameLen > SensorsPerBoard) begin
                  status_q <= 1'b1;
                  state_q  <= ST_DONE;
                end else begin
                  state_q <= ST_UPD;
                end
              end
              KIND_FRAME: state_q <= ST_FRM;
              KIND_STATS: state_q <= ST_STAT;
              default:    state_q <= ST_DONE;
            endcase
          end
        end
        ST_UPD: begin
          ub_q[step_q[1:0]] <= cur_under;
          ob_q[step_q[1:0]] <= cur_over;
          step_q <= step_q + 1'b1;
          if (step_q == 3'd3) begin
            state_q <= ST_DONE;
          end
        end
        ST_FRM: begin
          // issue a read at each step and capture the previous step's read
          rd_pend_q <= !step_q[2];
          if (rd_pend_q) begin
            if (32'(prev_s) < SensorsPerBoard) begin
              val_q[prev_lane] <= rd_val;
              pos_q[prev_lane] <= position_lookup(prev_s);
            end else begin
              val_q[prev_lane] <= '0;
              pos_q[prev_lane] <= NoPosition;
            end
          end
          step_q <= step_q + 1'b1;
          if (step_q == 3'd4) begin
            state_q <= ST_DONE;
            if (32'(rd_offset_q) + FrameLen >= SensorsPerBoard) begin
              rd_offset_q <= '0;
              rd_board_q  <= (32'(rd_board_q) + 1 >= Boards) ? 3'd0 : rd_board_q + 3'd1;
            end else begin
              rd_offset_q <= rd_offset_q + 6'(FrameLen);
            end
          end
        end
        ST_STAT: begin
          rd_pend_q <= 1'b1;
          if (addr_q != AddrW'(Cells - 1)) begin
            addr_q <= addr_q + 1'b1;
          end
          if (rd_pend_q) begin
            if (rd_val > mx_q) mx_q <= rd_val;
            if (rd_val < mn_q) mn_q <= rd_val;
            sum_q <= sum_fin;
            if (addr_q == AddrW'(Cells - 1) && step_q[0]) begin
              neg_q   <= sum_fin[SumW-1];
              quo_q   <= sum_fin[SumW-1] ? DivW'(-sum_fin) : DivW'(sum_fin);
              state_q <= ST_DIV;
            end
            if (addr_q == AddrW'(Cells - 1)) step_q[0] <= 1'b1;
          end
        end
        ST_DIV: begin
          // quotient magnitude of the average
          quo_q   <= DivW'(avg_prod >> RecipShift);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (step_q[0] && !rd_pend_q) begin
            step_q <= '0;
          end
          rvalid_q <= 1'b1;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // statistics results fold into the value lanes
  logic stat_res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_res_q <= 1'b0;
    end else if (state_q == ST_IDLE && start) begin
      stat_res_q <= (kind_e'(kind_i) == KIND_STATS);
    end
  end

  logic frame_res_q;
  logic [2:0] fb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_res_q <= 1'b0;
      fb_q <= '0;
    end else if (state_q == ST_IDLE && start) begin
      frame_res_q <= (kind_e'(kind_i) == KIND_FRAME);
      fb_q <= rd_board_q;
    end
  end

  logic signed [15:0] avg;
  assign avg = neg_q ? -quo_q[15:0] : quo_q[15:0];

  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign frame_board_o  = frame_res_q ? fb_q : 3'd0;
  assign value_a_o      = stat_res_q ? mx_q : val_q[0];
  assign value_b_o      = stat_res_q ? mn_q : val_q[1];
  assign value_c_o      = stat_res_q ? avg  : val_q[2];
  assign value_d_o      = stat_res_q ? 16'sd0 : val_q[3];
  assign position_a_o   = pos_q[0];
  assign position_b_o   = pos_q[1];
  assign position_c_o   = pos_q[2];
  assign position_d_o   = pos_q[3];
  assign under_bits_o   = ub_q;
  assign over_bits_o    = ob_q;

  `ASSERT_IMPL(a_res_after_done, clk_i, rst_ni, result_valid_o |-> $past(state_q) == ST_DONE)
  `ASSERT_NEVER(a_res_while_idle_start, clk_i, rst_ni, result_valid_o && state_q != ST_IDLE)
  `ASSERT_IMPL(a_reject_clean, clk_i, rst_ni, (result_valid_o && status_o) |-> (under_bits_o == 4'd0))
  `ASSERT_NEVER(a_write_outside_upd, clk_i, rst_ni, ram_we && state_q != ST_UPD && state_q != ST_CLEAR)
endmodule
